FILE: hw/rtl/tsrt_pkg.sv
// tsrt_pkg: shared types, constants and time helpers for the time sorted record table
// used by tsrt_ctrl, tsrt_datapath and time_sorted_record_table
`timescale 1ns / 1ps
`default_nettype none

package tsrt_pkg;

    localparam int unsigned DEPTH_DEFAULT = 16;

    localparam int unsigned CODE_W   = 40;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MIN_W    = 6;
    localparam int unsigned TIME_W   = 11;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned DATA_W   = 64;

    localparam int unsigned MIN_PER_HOUR = 60;
    // floor(t * 2185 / 2^17) equals t / 60 for every 11-bit t
    localparam int unsigned RECIP_60     = 2185;
    localparam int unsigned RECIP_SHIFT  = 17;
    localparam int unsigned PROD_W       = 23;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_DUMP   = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_REMOVED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_RECORD    = 3'd4,
        ST_EMPTY     = 3'd5
    } status_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [TIME_W-1:0] sched_time;
        logic              delay;
        logic [TIME_W-1:0] exp_time;
    } entry_t;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
    } hm_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_PUT,
        S_REM_SCAN,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_RESP
    } state_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_INS_START,
        DP_INS_SCAN,
        DP_INS_PUT,
        DP_REM_START,
        DP_REM_SCAN,
        DP_DUMP_START,
        DP_DUMP_RD,
        DP_DUMP_OUT,
        DP_RESP
    } dp_op_t;

    typedef struct packed {
        logic    capture;
        dp_op_t  op;
        status_t status;
    } dp_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic slot_free;
        logic ins_shift;
        logic idx_one;
        logic at_last;
        logic rem_hit;
    } dp_flags_t;

    function automatic logic [TIME_W-1:0] to_minutes(input logic [HOUR_W-1:0] h,
                                                     input logic [MIN_W-1:0]  m);
        return TIME_W'(TIME_W'(h) * TIME_W'(MIN_PER_HOUR)) + TIME_W'(m);
    endfunction

    function automatic hm_t split_time(input logic [TIME_W-1:0] t);
        logic [PROD_W-1:0] prod;
        logic [5:0]        q;
        logic [TIME_W-1:0] r;
        hm_t               hm;
        prod      = PROD_W'(t) * PROD_W'(RECIP_60);
        q         = prod[PROD_W-1:RECIP_SHIFT];
        r         = t - TIME_W'(TIME_W'(q) * TIME_W'(MIN_PER_HOUR));
        hm.hour   = q[HOUR_W-1:0];
        hm.minute = r[MIN_W-1:0];
        return hm;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tsrt_ram.sv
// tsrt_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tsrt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/tsrt_ctrl.sv
// tsrt_ctrl: state machine sequencing insert, remove and dump requests
// depends on tsrt_pkg
`timescale 1ns / 1ps
`default_nettype none

module tsrt_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    input  wire logic [tsrt_pkg::KIND_W-1:0]   s_tuser,
    output logic                               s_tready,
    input  wire tsrt_pkg::dp_flags_t           flags,
    output tsrt_pkg::dp_cmd_t                  cmd
);

    tsrt_pkg::state_t  state_reg, state_next;
    tsrt_pkg::status_t resp_reg, resp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsrt_pkg::S_IDLE;
            resp_reg  <= tsrt_pkg::ST_INSERTED;
        end
        else
        begin
            state_reg <= state_next;
            resp_reg  <= resp_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        resp_next   = resp_reg;
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.op      = tsrt_pkg::DP_NONE;
        cmd.status  = resp_reg;

        unique case (state_reg)
            tsrt_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    unique case (tsrt_pkg::kind_t'(s_tuser))
                        tsrt_pkg::KIND_INSERT:
                        begin
                            if (flags.count_full)
                            begin
                                resp_next  = tsrt_pkg::ST_FULL;
                                state_next = tsrt_pkg::S_RESP;
                            end
                            else
                            begin
                                cmd.op     = tsrt_pkg::DP_INS_START;
                                state_next = flags.count_zero ? tsrt_pkg::S_INS_PUT
                                                              : tsrt_pkg::S_INS_SCAN;
                            end
                        end
                        tsrt_pkg::KIND_REMOVE:
                        begin
                            if (flags.count_zero)
                            begin
                                resp_next  = tsrt_pkg::ST_NOT_FOUND;
                                state_next = tsrt_pkg::S_RESP;
                            end
                            else
                            begin
                                cmd.op     = tsrt_pkg::DP_REM_START;
                                state_next = tsrt_pkg::S_REM_SCAN;
                            end
                        end
                        tsrt_pkg::KIND_DUMP:
                        begin
                            if (flags.count_zero)
                            begin
                                resp_next  = tsrt_pkg::ST_EMPTY;
                                state_next = tsrt_pkg::S_RESP;
                            end
                            else
                            begin
                                cmd.op     = tsrt_pkg::DP_DUMP_START;
                                state_next = tsrt_pkg::S_DUMP_RD;
                            end
                        end
                        default:
                        begin
                            // unused kind code: dropped without a response
                            state_next = tsrt_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            tsrt_pkg::S_INS_SCAN:
            begin
                cmd.op = tsrt_pkg::DP_INS_SCAN;
                if (flags.ins_shift)
                begin
                    if (flags.idx_one)
                    begin
                        state_next = tsrt_pkg::S_INS_PUT;
                    end
                end
                else
                begin
                    resp_next  = tsrt_pkg::ST_INSERTED;
                    state_next = tsrt_pkg::S_RESP;
                end
            end

            tsrt_pkg::S_INS_PUT:
            begin
                cmd.op     = tsrt_pkg::DP_INS_PUT;
                resp_next  = tsrt_pkg::ST_INSERTED;
                state_next = tsrt_pkg::S_RESP;
            end

            tsrt_pkg::S_REM_SCAN:
            begin
                cmd.op = tsrt_pkg::DP_REM_SCAN;
                if (flags.at_last)
                begin
                    resp_next  = flags.rem_hit ? tsrt_pkg::ST_REMOVED : tsrt_pkg::ST_NOT_FOUND;
                    state_next = tsrt_pkg::S_RESP;
                end
            end

            tsrt_pkg::S_DUMP_RD:
            begin
                cmd.op     = tsrt_pkg::DP_DUMP_RD;
                state_next = tsrt_pkg::S_DUMP_OUT;
            end

            tsrt_pkg::S_DUMP_OUT:
            begin
                if (flags.slot_free)
                begin
                    cmd.op     = tsrt_pkg::DP_DUMP_OUT;
                    state_next = flags.at_last ? tsrt_pkg::S_IDLE : tsrt_pkg::S_DUMP_RD;
                end
            end

            tsrt_pkg::S_RESP:
            begin
                if (flags.slot_free)
                begin
                    cmd.op     = tsrt_pkg::DP_RESP;
                    state_next = tsrt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = tsrt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tsrt_datapath.sv
// tsrt_datapath: record ram, request and index registers, entry count and output register
// depends on tsrt_pkg and tsrt_ram
`timescale 1ns / 1ps
`default_nettype none

module tsrt_datapath #(
    parameter int unsigned DEPTH = tsrt_pkg::DEPTH_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire tsrt_pkg::dp_cmd_t                cmd,
    output tsrt_pkg::dp_flags_t                   flags,
    input  wire logic [tsrt_pkg::DATA_W-1:0]      s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [tsrt_pkg::DATA_W-1:0]      m_tdata,
    output logic      [tsrt_pkg::STATUS_W-1:0]    m_tuser,
    output logic                                  m_tlast
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    tsrt_pkg::entry_t req_reg, req_next;
    tsrt_pkg::entry_t rd_entry, wr_entry;

    logic [AW-1:0] idx_reg, idx_next;
    logic [CW-1:0] count_reg, count_next;
    logic          found_reg, found_next;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;

    logic [CW-1:0] count_m1;
    logic          code_hit;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [tsrt_pkg::DATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [tsrt_pkg::STATUS_W-1:0] m_tuser_reg, m_tuser_next;
    logic                          m_tlast_reg, m_tlast_next;
    logic                          out_load;

    tsrt_pkg::hm_t sched_hm, exp_hm;

    tsrt_ram #(
        .WIDTH ($bits(tsrt_pkg::entry_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    assign count_m1 = count_reg - CW'(1);
    assign code_hit = (rd_entry.code == req_reg.code);

    assign flags.count_zero = (count_reg == '0);
    assign flags.count_full = (count_reg == CW'(DEPTH));
    assign flags.slot_free  = !m_tvalid_reg || m_tready;
    // stored record is later than the new one, so it moves up a slot
    assign flags.ins_shift  = (rd_entry.sched_time > req_reg.sched_time);
    assign flags.idx_one    = (idx_reg == AW'(1));
    assign flags.at_last    = (CW'(idx_reg) == count_m1);
    assign flags.rem_hit    = found_reg || code_hit;

    assign sched_hm = tsrt_pkg::split_time(rd_entry.sched_time);
    assign exp_hm   = tsrt_pkg::split_time(rd_entry.exp_time);

    // request capture: code, hour, minute, delay, expected hour, expected minute
    always_comb
    begin
        req_next = req_reg;
        if (cmd.capture)
        begin
            req_next.code       = s_tdata[39:0];
            req_next.sched_time = tsrt_pkg::to_minutes(s_tdata[44:40], s_tdata[50:45]);
            req_next.delay      = s_tdata[51];
            req_next.exp_time   = tsrt_pkg::to_minutes(s_tdata[56:52], s_tdata[62:57]);
        end
    end

    always_comb
    begin
        idx_next     = idx_reg;
        count_next   = count_reg;
        found_next   = found_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_entry     = rd_entry;
        rd_en        = 1'b0;
        rd_addr      = idx_reg;
        out_load     = 1'b0;
        m_tdata_next = '0;
        m_tuser_next = m_tuser_reg;
        m_tlast_next = 1'b1;

        unique case (cmd.op)
            tsrt_pkg::DP_NONE:
            begin
                idx_next = idx_reg;
            end
            tsrt_pkg::DP_INS_START:
            begin
                idx_next = count_reg[AW-1:0];
                rd_en    = 1'b1;
                rd_addr  = count_m1[AW-1:0];
            end
            tsrt_pkg::DP_INS_SCAN:
            begin
                wr_en = 1'b1;
                if (flags.ins_shift)
                begin
                    wr_entry = rd_entry;
                    idx_next = idx_reg - AW'(1);
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg - AW'(2);
                end
                else
                begin
                    wr_entry   = req_reg;
                    count_next = count_reg + CW'(1);
                end
            end
            tsrt_pkg::DP_INS_PUT:
            begin
                wr_en      = 1'b1;
                wr_entry   = req_reg;
                count_next = count_reg + CW'(1);
            end
            tsrt_pkg::DP_REM_START:
            begin
                idx_next   = '0;
                found_next = 1'b0;
                rd_en      = 1'b1;
                rd_addr    = '0;
            end
            tsrt_pkg::DP_REM_SCAN:
            begin
                // once the match is behind us every record slides down one slot
                if (found_reg)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = idx_reg - AW'(1);
                    wr_entry = rd_entry;
                end
                found_next = found_reg || code_hit;
                if (flags.at_last)
                begin
                    if (flags.rem_hit)
                    begin
                        count_next = count_m1;
                    end
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + AW'(1);
                end
            end
            tsrt_pkg::DP_DUMP_START:
            begin
                idx_next = '0;
            end
            tsrt_pkg::DP_DUMP_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg;
            end
            tsrt_pkg::DP_DUMP_OUT:
            begin
                out_load     = 1'b1;
                m_tdata_next = {1'b0, exp_hm.minute, exp_hm.hour, rd_entry.delay,
                                sched_hm.minute, sched_hm.hour, rd_entry.code};
                m_tuser_next = tsrt_pkg::ST_RECORD;
                m_tlast_next = flags.at_last;
                if (!flags.at_last)
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            tsrt_pkg::DP_RESP:
            begin
                out_load     = 1'b1;
                m_tuser_next = cmd.status;
                m_tlast_next = 1'b1;
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        if (out_load)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
            m_tlast_reg <= m_tlast_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/time_sorted_record_table.sv
// time_sorted_record_table: top level joining the controller and the datapath
// depends on tsrt_pkg, tsrt_ctrl, tsrt_datapath and tsrt_ram
//
// Holds up to DEPTH records sorted by scheduled time (hour*60+minute) in one ram with a
// single write and a single registered read port. A request carries its kind in s_tuser:
// insert (placed after every record with an equal or earlier time, status full when the
// table is full), remove (first record with the same code, else not found) or dump (one
// response per record in time order with m_tlast on the last, or a single empty status).
// Insert and remove answer with one status response. Requests are taken one at a time:
// s_tready is high only between requests. Insert and remove scan the stored records
// through the ram read port, one record per cycle; a dump reads each record and then
// loads it into the output register, waiting while the output stalls. A finished response
// waits in the output register while the next request is already accepted.
`timescale 1ns / 1ps
`default_nettype none

module time_sorted_record_table #(
    parameter int unsigned DEPTH = tsrt_pkg::DEPTH_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // flight_code, sched_hour, sched_minute, is_delayed, expect_hour, expect_minute, pad
    input  wire logic [tsrt_pkg::DATA_W-1:0]      s_tdata,
    // kind
    input  wire logic [tsrt_pkg::KIND_W-1:0]      s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // out_code, out_hour, out_minute, out_delayed, out_expect_hour, out_expect_minute, pad
    output logic      [tsrt_pkg::DATA_W-1:0]      m_tdata,
    // status
    output logic      [tsrt_pkg::STATUS_W-1:0]    m_tuser,
    output logic                                  m_tlast
);

    tsrt_pkg::dp_cmd_t   cmd;
    tsrt_pkg::dp_flags_t flags;

    tsrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .flags    (flags),
        .cmd      (cmd)
    );

    tsrt_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .flags    (flags),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

FILE: tb/tb_time_sorted_record_table.sv
// tb_time_sorted_record_table: stream testbench for the time sorted record table
// depends on tsrt_pkg and time_sorted_record_table; predicts every response in order
`timescale 1ns / 1ps
`default_nettype none

module tb_time_sorted_record_table;
    import tsrt_pkg::*;

    localparam int unsigned TABLE_DEPTH = DEPTH_DEFAULT;
    localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;
    localparam int RAND_REQUESTS = 320;
    localparam int CALM_TAIL = 40;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] data;
        bit                hold;
        int                send_pct;
        int                recv_pct;
    } req_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [CODE_W-1:0]   code;
        logic [HOUR_W-1:0]   hour;
        logic [MIN_W-1:0]    minute;
        logic                delayed;
        logic [HOUR_W-1:0]   exp_hour;
        logic [MIN_W-1:0]    exp_minute;
        logic                last;
    } resp_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata = '0;
    logic [KIND_W-1:0]   s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [DATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic                m_tlast;

    // predicted contents of the table, kept sorted by scheduled time
    logic [CODE_W-1:0] slot_code [TABLE_DEPTH];
    int                slot_time [TABLE_DEPTH];
    logic              slot_delay [TABLE_DEPTH];
    int                slot_expect [TABLE_DEPTH];
    int                slot_used = 0;

    req_t  pending [$];
    resp_t resp_due [$];
    int    issued_cnt = 0;
    int    taken_cnt = 0;
    int    fail_cnt = 0;
    int    send_gap = 0;
    int    rcv_gap = 0;
    int    recv_pct = 0;

    // stimulus side bookkeeping: codes the table holds as the requests are built
    logic [CODE_W-1:0] gen_codes [$];
    logic [CODE_W-1:0] code_pool [6];
    int                cur_send_pct = 0;
    int                cur_recv_pct = 0;

    time_sorted_record_table #(
        .DEPTH(TABLE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic void add_req(input logic [KIND_W-1:0] kind, input logic [CODE_W-1:0] code,
                                    input int sh, input int sm, input int dly,
                                    input int eh, input int em, input bit hold);
        req_t r;
        int   i;
        r.kind = kind;
        r.data = {1'b0, MIN_W'(em), HOUR_W'(eh), 1'(dly), MIN_W'(sm), HOUR_W'(sh), code};
        r.hold = hold;
        r.send_pct = cur_send_pct;
        r.recv_pct = cur_recv_pct;
        pending.push_back(r);
        if (kind == KIND_INSERT && gen_codes.size() < TABLE_DEPTH)
            gen_codes.push_back(code);
        else if (kind == KIND_REMOVE)
        begin
            for (i = 0; i < gen_codes.size(); i++)
            begin
                if (gen_codes[i] == code)
                begin
                    gen_codes.delete(i);
                    break;
                end
            end
        end
    endfunction

    function automatic logic [CODE_W-1:0] any_code();
        if ($urandom_range(0, 1) == 0)
            return code_pool[$urandom_range(0, 5)];
        return CODE_W'({$urandom(), $urandom()});
    endfunction

    function automatic int any_hour();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(24, 31);
        return $urandom_range(0, 23);
    endfunction

    function automatic int any_minute();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(60, 63);
        return $urandom_range(0, 59);
    endfunction

    function automatic void add_random_insert();
        int sh;
        int sm;
        // a narrow band of times gives many ties
        if ($urandom_range(0, 2) == 0)
        begin
            sh = $urandom_range(7, 8);
            sm = 30 * $urandom_range(0, 1);
        end
        else
        begin
            sh = any_hour();
            sm = any_minute();
        end
        add_req(KIND_INSERT, any_code(), sh, sm, $urandom_range(0, 1), any_hour(), any_minute(),
                1'b0);
    endfunction

    function automatic void add_random_remove();
        logic [CODE_W-1:0] code;
        if (gen_codes.size() != 0 && $urandom_range(0, 4) != 0)
            code = gen_codes[$urandom_range(0, gen_codes.size() - 1)];
        else
            code = any_code();
        add_req(KIND_REMOVE, code, $urandom_range(0, 31), $urandom_range(0, 63),
                $urandom_range(0, 1), $urandom_range(0, 31), $urandom_range(0, 63), 1'b0);
    endfunction

    // expected responses for one accepted request, table updated in place
    function automatic void apply_request(input logic [DATA_W-1:0] d,
                                          input logic [KIND_W-1:0] kind);
        logic [CODE_W-1:0] code;
        int                t;
        int                e;
        int                pos;
        int                i;
        resp_t             r;
        code = d[39:0];
        t = int'(d[44:40]) * 60 + int'(d[50:45]);
        e = int'(d[56:52]) * 60 + int'(d[62:57]);
        r.status = ST_INSERTED;
        r.code = '0;
        r.hour = '0;
        r.minute = '0;
        r.delayed = 1'b0;
        r.exp_hour = '0;
        r.exp_minute = '0;
        r.last = 1'b1;
        if (kind == KIND_INSERT)
        begin
            if (slot_used >= TABLE_DEPTH)
                r.status = ST_FULL;
            else
            begin
                pos = 0;
                while (pos < slot_used && slot_time[pos] <= t)
                    pos++;
                for (i = slot_used; i > pos; i--)
                begin
                    slot_code[i] = slot_code[i-1];
                    slot_time[i] = slot_time[i-1];
                    slot_delay[i] = slot_delay[i-1];
                    slot_expect[i] = slot_expect[i-1];
                end
                slot_code[pos] = code;
                slot_time[pos] = t;
                slot_delay[pos] = d[51];
                slot_expect[pos] = e;
                slot_used++;
            end
            resp_due.push_back(r);
        end
        else if (kind == KIND_REMOVE)
        begin
            pos = 0;
            while (pos < slot_used && slot_code[pos] != code)
                pos++;
            if (pos >= slot_used)
                r.status = ST_NOT_FOUND;
            else
            begin
                for (i = pos; i + 1 < slot_used; i++)
                begin
                    slot_code[i] = slot_code[i+1];
                    slot_time[i] = slot_time[i+1];
                    slot_delay[i] = slot_delay[i+1];
                    slot_expect[i] = slot_expect[i+1];
                end
                slot_used--;
                r.status = ST_REMOVED;
            end
            resp_due.push_back(r);
        end
        else if (kind == KIND_DUMP)
        begin
            if (slot_used == 0)
            begin
                r.status = ST_EMPTY;
                resp_due.push_back(r);
            end
            for (i = 0; i < slot_used; i++)
            begin
                r.status = ST_RECORD;
                r.code = slot_code[i];
                r.hour = HOUR_W'(slot_time[i] / 60);
                r.minute = MIN_W'(slot_time[i] % 60);
                r.delayed = slot_delay[i];
                r.exp_hour = HOUR_W'(slot_expect[i] / 60);
                r.exp_minute = MIN_W'(slot_expect[i] % 60);
                r.last = (i == slot_used - 1);
                resp_due.push_back(r);
            end
        end
    endfunction

    task automatic cmp_field(input string name, input logic [CODE_W-1:0] exp_v,
                             input logic [CODE_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    task automatic check_response(input logic [DATA_W-1:0] d, input logic [STATUS_W-1:0] st,
                                  input logic lst);
        resp_t r;
        if (resp_due.size() == 0)
        begin
            $error("response with none outstanding: status %0d code 0x%0h", st, d[39:0]);
            fail_cnt++;
        end
        else
        begin
            r = resp_due.pop_front();
            cmp_field("status", r.status, st);
            cmp_field("out_code", r.code, d[39:0]);
            cmp_field("out_hour", r.hour, d[44:40]);
            cmp_field("out_minute", r.minute, d[50:45]);
            cmp_field("out_delayed", r.delayed, d[51]);
            cmp_field("out_expect_hour", r.exp_hour, d[56:52]);
            cmp_field("out_expect_minute", r.exp_minute, d[62:57]);
            cmp_field("last", r.last, lst);
        end
    endtask

    // monitor: responses are checked and requests predicted at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_response(m_tdata, m_tuser, m_tlast);
            if (s_tvalid && s_tready)
            begin
                apply_request(s_tdata, s_tuser);
                taken_cnt <= taken_cnt + 1;
            end
        end
    end

    // driver: a presented request stays until taken, then an optional idle burst
    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && taken_cnt != issued_cnt))
        begin
            if (send_gap != 0)
            begin
                s_tvalid <= 1'b0;
                send_gap = send_gap - 1;
            end
            else if (pending.size() != 0 && !(pending[0].hold && resp_due.size() != 0))
            begin
                s_tvalid <= 1'b1;
                s_tdata <= pending[0].data;
                s_tuser <= pending[0].kind;
                recv_pct = pending[0].recv_pct;
                if ($urandom_range(0, 99) < pending[0].send_pct)
                    send_gap = $urandom_range(1, 15);
                void'(pending.pop_front());
                issued_cnt++;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rcv_gap != 0)
            begin
                m_tready <= 1'b0;
                rcv_gap = rcv_gap - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < recv_pct)
                    rcv_gap = $urandom_range(1, 15);
            end
        end
    end

    initial
    begin
        int n;
        int phase;
        int mode;
        int plen;
        int k;
        int r;
        int ins_pct;
        code_pool[0] = "QX101";
        code_pool[1] = "QX102";
        code_pool[2] = "LM777";
        code_pool[3] = "AB000";
        code_pool[4] = "ZZ999";
        code_pool[5] = "KP450";

        // directed: empty table, extremes, ties, duplicates, out of range times, kind 3
        cur_send_pct = 20;
        cur_recv_pct = 10;
        add_req(KIND_DUMP, '0, 0, 0, 0, 0, 0, 1'b0);
        add_req(KIND_REMOVE, "QX101", 0, 0, 0, 0, 0, 1'b0);
        add_req(KIND_IGNORED, '1, 31, 63, 1, 31, 63, 1'b0);
        add_req(KIND_INSERT, '0, 0, 0, 0, 0, 0, 1'b0);
        add_req(KIND_INSERT, '1, 23, 59, 1, 23, 59, 1'b0);
        add_req(KIND_INSERT, "QX101", 12, 30, 0, 12, 45, 1'b0);
        add_req(KIND_INSERT, "QX102", 12, 30, 1, 13, 0, 1'b0);
        add_req(KIND_INSERT, "QX101", 6, 15, 1, 6, 40, 1'b0);
        add_req(KIND_INSERT, "LM777", 31, 63, 1, 31, 63, 1'b0);
        add_req(KIND_INSERT, "AB000", 0, 63, 0, 24, 0, 1'b0);
        add_req(KIND_INSERT, "ZZ999", 12, 30, 0, 0, 0, 1'b0);
        add_req(KIND_DUMP, '1, 31, 63, 1, 31, 63, 1'b0);
        add_req(KIND_REMOVE, "QX101", 0, 0, 0, 0, 0, 1'b0);
        add_req(KIND_REMOVE, "KP450", 0, 0, 0, 0, 0, 1'b0);
        add_req(KIND_IGNORED, '0, 0, 0, 0, 0, 0, 1'b0);
        add_req(KIND_DUMP, '0, 0, 0, 0, 0, 0, 1'b0);
        add_req(KIND_REMOVE, '1, 0, 0, 0, 0, 0, 1'b0);
        add_req(KIND_REMOVE, '0, 0, 0, 0, 0, 0, 1'b0);
        add_req(KIND_DUMP, '0, 0, 0, 0, 0, 0, 1'b1);

        // random phases: fill, drain or mixed, each with its own idle pressure
        n = 0;
        phase = 0;
        while (n < RAND_REQUESTS)
        begin
            mode = (phase == 0) ? 0 : $urandom_range(0, 2);
            plen = $urandom_range(15, 50);
            case ($urandom_range(0, 3))
                0: cur_send_pct = 0;
                1: cur_send_pct = 5;
                2: cur_send_pct = 20;
                default: cur_send_pct = 50;
            endcase
            case ($urandom_range(0, 3))
                0: cur_recv_pct = 0;
                1: cur_recv_pct = 3;
                2: cur_recv_pct = 10;
                default: cur_recv_pct = 25;
            endcase
            ins_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
            if (phase == 0)
            begin
                // overfill once for sure, then show the full table
                while (gen_codes.size() < TABLE_DEPTH)
                begin
                    add_random_insert();
                    n++;
                end
                for (k = 0; k < 3; k++)
                    add_random_insert();
                add_req(KIND_DUMP, any_code(), 0, 0, 0, 0, 0, 1'b0);
                n += 4;
            end
            else if ($urandom_range(0, 2) == 0)
                add_req(KIND_DUMP, any_code(), any_hour(), any_minute(), 0, 0, 0, 1'b1);
            for (k = 0; k < plen; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    add_req(KIND_IGNORED, any_code(), any_hour(), any_minute(),
                            $urandom_range(0, 1), any_hour(), any_minute(), 1'b0);
                else
                begin
                    if (r < 10)
                        add_req(KIND_DUMP, any_code(), $urandom_range(0, 31),
                                $urandom_range(0, 63), $urandom_range(0, 1),
                                $urandom_range(0, 31), $urandom_range(0, 63), 1'b0);
                    else if ($urandom_range(0, 99) < ins_pct)
                        add_random_insert();
                    else
                        add_random_remove();
                    n++;
                end
            end
            phase++;
        end
        add_req(KIND_DUMP, '0, 0, 0, 0, 0, 0, 1'b0);
        for (k = pending.size() - CALM_TAIL; k < pending.size(); k++)
        begin
            pending[k].send_pct = 0;
            pending[k].recv_pct = 0;
        end

        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending.size() != 0 || taken_cnt != issued_cnt)
            @(posedge clk);
        while (resp_due.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (fail_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/tsrt_pkg.sv
hw/rtl/tsrt_ram.sv
hw/rtl/tsrt_ctrl.sv
hw/rtl/tsrt_datapath.sv
hw/rtl/time_sorted_record_table.sv
tb/tb_time_sorted_record_table.sv
